// ===== hdl/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants, register codes and the cosine weight table for the
// two-dimensional fractal value noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

  // Sizing of the block.
  localparam int TABLE_DEPTH    = 4096;
  localparam int MAX_OCTAVES    = 8;
  localparam int VALUE_BITS     = 16;
  localparam int COS_TABLE_BITS = 10;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  // Item fields.
  localparam int ENTRY_ADDR_W  = 12;
  localparam int ENTRY_VALUE_W = 16;
  localparam int COORD_W       = 24;
  localparam int NOISE_W       = 24;
  localparam int NOISE_MAX     = (1 << (NOISE_W - 1)) - 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration port.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OCT_CFG_W   = 4;
  localparam int PERS_W      = 16;
  localparam int CELL_SIZE_W = 8;
  localparam int STRIDE_W    = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_COUNT = 2'd0,
    CFG_PERSISTENCE  = 2'd1,
    CFG_CELL_SIZE    = 2'd2,
    CFG_ROW_STRIDE   = 2'd3
  } cfg_index_t;

  // Cell divider: dividend is coord * 2^COS_TABLE_BITS, divisor cell_size * 256.
  localparam int SHIFT_W   = COORD_W + MAX_OCTAVES - 1;
  localparam int DIVS_W    = CELL_SIZE_W + 8;
  localparam int DIVD_W    = COORD_W + COS_TABLE_BITS;
  localparam int QUO_W     = SHIFT_W - 8 + COS_TABLE_BITS;
  localparam int CELL_W    = SHIFT_W - 8;
  localparam int REM_W     = DIVS_W + 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int IDX_W     = CELL_W + 1 + STRIDE_W + 1;
  localparam int OCT_W     = $clog2(MAX_OCTAVES + 1);

  // Blend and accumulate datapath.
  localparam int WEIGHT_W = 17;
  localparam int P_W      = 17;
  localparam int T_W      = VALUE_BITS + 9;
  localparam int PX_W     = VALUE_BITS + 1 + WEIGHT_W + 1;
  localparam int YX_W     = T_W + 1 + WEIGHT_W + 1;
  localparam int AX_W     = T_W + P_W + 1;
  localparam int SUM_W    = T_W + $clog2(MAX_OCTAVES) + 1;
  localparam int NUM_W    = SUM_W + P_W + 1;
  localparam int DEN_W    = P_W;
  localparam int FREM_W   = DEN_W + 1;
  localparam int FCNT_W   = $clog2(NUM_W);

  // Cosine weight table, built at elaboration from a Q2.30 Taylor series.
  localparam int     COS_ENTRIES = 1 << COS_TABLE_BITS;
  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint SIN_DENOM [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef logic [WEIGHT_W-1:0] cos_lut_t [COS_ENTRIES];

  function automatic longint sin_q30(input longint u);
    longint u2;
    longint term;
    longint sum;
    u2   = (u * u) / Q30_ONE;
    term = u;
    sum  = u;
    for (int n = 0; n < 7; n++) begin
      term = -((term * u2) / Q30_ONE) / SIN_DENOM[n];
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic cos_lut_t build_cos();
    cos_lut_t lut;
    longint   u;
    longint   s;
    longint   w;
    for (int k = 0; k < COS_ENTRIES; k++) begin
      u = ((longint'(k) * PI_Q30) >>> COS_TABLE_BITS) - PI_Q30 / 2;
      s = Q30_ONE + sin_q30(u);
      if (s < 0) begin
        s = 0;
      end
      w = (s + (64'sd1 << 14)) >>> 15;
      if (w > 65536) begin
        w = 65536;
      end
      lut[k] = WEIGHT_W'(w);
    end
    return lut;
  endfunction

  localparam cos_lut_t COS_LUT = build_cos();

endpackage

// ===== hdl/fvn_in_if.sv =====
// ----------------------------------------------------------------------------
// fvn_in_if
// Input item channel: table writes and noise queries.
// ----------------------------------------------------------------------------
interface fvn_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     opcode;
  logic [fvn_pkg::ENTRY_ADDR_W-1:0]         entry_address;
  logic signed [fvn_pkg::ENTRY_VALUE_W-1:0] entry_value;
  logic [fvn_pkg::COORD_W-1:0]              coord_x;
  logic [fvn_pkg::COORD_W-1:0]              coord_y;

  modport source (
    output valid, opcode, entry_address, entry_value, coord_x, coord_y,
    input  ready
  );

  modport sink (
    input  valid, opcode, entry_address, entry_value, coord_x, coord_y,
    output ready
  );
endinterface

// ===== hdl/fvn_out_if.sv =====
// ----------------------------------------------------------------------------
// fvn_out_if
// Result item channel: normalized noise value and range flag.
// ----------------------------------------------------------------------------
interface fvn_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fvn_pkg::NOISE_W-1:0] noise_value;
  logic                               index_out_of_range;

  modport source (
    output valid, noise_value, index_out_of_range,
    input  ready
  );

  modport sink (
    input  valid, noise_value, index_out_of_range,
    output ready
  );
endinterface

// ===== hdl/fractal_value_noise_2d.sv =====
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fractal value noise over a loaded lattice table, cosine interpolated and
// summed over a configurable number of octaves.
// ----------------------------------------------------------------------------
// A write item (opcode 0) stores one lattice value; it causes no result. A
// query item (opcode 1) is worked on alone, in three parts: a 34-step serial
// divider that splits both coordinates into cell and fraction at once, four
// reads per octave through the single read port of the lattice memory, and
// a 47-step serial divider for the final normalization. Further octaves
// reuse the first division by one doubling step each. The result sits in an
// output register, so the next item is taken while it waits. The lattice
// memory has no reset; entries must be written before a query reads them.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d (
  input  logic                             clk,
  input  logic                             rst_n,
  fvn_in_if.sink                           in_ch,
  fvn_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fvn_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIVXY = 13'b0000000000010,
    S_SETUP = 13'b0000000000100,
    S_READ  = 13'b0000000001000,
    S_TOP   = 13'b0000000010000,
    S_BOT   = 13'b0000000100000,
    S_VMUL  = 13'b0000001000000,
    S_ACC   = 13'b0000010000000,
    S_NEXT  = 13'b0000100000000,
    S_MULF  = 13'b0001000000000,
    S_ABS   = 13'b0010000000000,
    S_FDIV  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [fvn_pkg::OCT_CFG_W-1:0]   oct_cfg_r;
  logic [fvn_pkg::PERS_W-1:0]      pers_r;
  logic [fvn_pkg::CELL_SIZE_W-1:0] csize_r;
  logic [fvn_pkg::STRIDE_W-1:0]    stride_r;

  // Cell divider and per-octave stepping.
  logic [fvn_pkg::DIVD_W-1:0]    dvd_x_r, dvd_x_nxt, dvd_y_r, dvd_y_nxt;
  logic [fvn_pkg::REM_W-1:0]     rx_r, rx_nxt, ry_r, ry_nxt;
  logic [fvn_pkg::QUO_W-1:0]     qx_r, qx_nxt, qy_r, qy_nxt;
  logic [fvn_pkg::DIVS_W-1:0]    d_r, d_nxt;
  logic [fvn_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [fvn_pkg::OCT_W-1:0]     oct_r, oct_nxt, n_r, n_nxt;

  // Corner fetch.
  logic [fvn_pkg::CELL_W-1:0]   cy_r, cy_nxt;
  logic [fvn_pkg::IDX_W-1:0]    base_r, base_nxt;
  logic [fvn_pkg::WEIGHT_W-1:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic [2:0]                   rd_cnt_r, rd_cnt_nxt;
  logic                         pend_oor_r, pend_oor_nxt;
  logic                         oor_r, oor_nxt;
  logic signed [fvn_pkg::VALUE_BITS-1:0] corner_r [4];
  logic signed [fvn_pkg::VALUE_BITS-1:0] corner_nxt [4];

  // Blend and accumulation.
  logic signed [fvn_pkg::T_W-1:0]   top_r, top_nxt, bot_r, bot_nxt, v_r, v_nxt;
  logic signed [fvn_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [fvn_pkg::P_W-1:0]          p_r, p_nxt;

  // Normalization divider.
  logic [fvn_pkg::NUM_W-1:0]  fdvd_r, fdvd_nxt, fquo_r, fquo_nxt;
  logic [fvn_pkg::FREM_W-1:0] frem_r, frem_nxt;
  logic [fvn_pkg::DEN_W-1:0]  den_r, den_nxt;
  logic [fvn_pkg::FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic                       fneg_r, fneg_nxt;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  logic signed [fvn_pkg::NOISE_W-1:0] out_noise_r, out_noise_nxt;
  logic                               out_oor_r, out_oor_nxt;

  // Lattice memory port.
  logic                               ram_we;
  logic [fvn_pkg::ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [fvn_pkg::VALUE_BITS-1:0]     ram_wdata, ram_rdata;

  logic in_acc;

  // Datapath terms.
  logic [fvn_pkg::REM_W-1:0]           rx_sh, ry_sh;
  logic                                x_ge, y_ge;
  logic [fvn_pkg::IDX_W-1:0]           rd_idx;
  logic                                rd_in_range;
  logic [1:0]                          cap_sel;
  logic signed [fvn_pkg::VALUE_BITS-1:0] bl_a, bl_b;
  logic signed [fvn_pkg::VALUE_BITS:0]   xdiff;
  logic signed [fvn_pkg::PX_W-1:0]     xprod, xq;
  logic signed [fvn_pkg::T_W-1:0]      xres;
  logic signed [fvn_pkg::T_W:0]        ydiff;
  logic signed [fvn_pkg::YX_W-1:0]     yprod, yq;
  logic signed [fvn_pkg::T_W-1:0]      yres;
  logic signed [fvn_pkg::AX_W-1:0]     aprod, aq;
  logic [fvn_pkg::P_W+fvn_pkg::PERS_W:0] pprod;
  logic [fvn_pkg::P_W-1:0]             pers_cmp;
  logic signed [fvn_pkg::NUM_W-1:0]    fprod;
  logic [fvn_pkg::FREM_W-1:0]          frem_sh;
  logic                                f_ge;
  logic                                pos_sat, neg_sat;
  logic signed [fvn_pkg::NOISE_W-1:0]  noise_res;
  logic [fvn_pkg::CELL_W-1:0]          cx_cell;
  logic [fvn_pkg::CELL_SIZE_W-1:0]     cs_eff;

  // --------------------------------------------------------------------------
  // Handshake and table writes. Only the idle sequencer takes an item, and a
  // write lands in the memory in the same cycle it is accepted.
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign ram_we    = in_acc && (in_ch.opcode == fvn_pkg::OP_WRITE) &&
                     (32'(in_ch.entry_address) < fvn_pkg::TABLE_DEPTH);
  assign ram_waddr = fvn_pkg::ADDR_W'(in_ch.entry_address);
  assign ram_wdata = fvn_pkg::VALUE_BITS'(in_ch.entry_value);

  fvn_ram #(
    .WIDTH (fvn_pkg::VALUE_BITS),
    .DEPTH (fvn_pkg::TABLE_DEPTH)
  ) u_lattice (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid              = out_valid_r;
  assign out_ch.noise_value        = out_noise_r;
  assign out_ch.index_out_of_range = out_oor_r;

  // --------------------------------------------------------------------------
  // Cell divider step. The quotient is floor(coord * 2^o * 2^B / d); its upper
  // bits are the cell and its lower B bits index the cosine table. After the
  // division the dividend has shifted out to zero, so the same step doubles
  // the quotient for the next octave.
  // --------------------------------------------------------------------------
  assign rx_sh = {rx_r[fvn_pkg::REM_W-2:0], dvd_x_r[fvn_pkg::DIVD_W-1]};
  assign ry_sh = {ry_r[fvn_pkg::REM_W-2:0], dvd_y_r[fvn_pkg::DIVD_W-1]};
  assign x_ge  = rx_sh >= fvn_pkg::REM_W'(d_r);
  assign y_ge  = ry_sh >= fvn_pkg::REM_W'(d_r);

  assign cs_eff  = (csize_r == '0) ? fvn_pkg::CELL_SIZE_W'(1) : csize_r;
  assign cx_cell = qx_r[fvn_pkg::QUO_W-1:fvn_pkg::COS_TABLE_BITS];

  // Corner index: bit 0 of the fetch count steps x, bit 1 steps y.
  assign rd_idx = base_r
                + (rd_cnt_r[0] ? fvn_pkg::IDX_W'(stride_r) : '0)
                + fvn_pkg::IDX_W'(cy_r)
                + fvn_pkg::IDX_W'(rd_cnt_r[1]);
  assign rd_in_range = rd_idx < fvn_pkg::IDX_W'(fvn_pkg::TABLE_DEPTH);
  assign ram_raddr   = rd_idx[fvn_pkg::ADDR_W-1:0];
  assign cap_sel     = 2'(rd_cnt_r - 3'd1);

  // Blend along x, shared by the top and bottom rows.
  assign bl_a  = (state_r == S_BOT) ? corner_r[2] : corner_r[0];
  assign bl_b  = (state_r == S_BOT) ? corner_r[3] : corner_r[1];
  assign xdiff = (fvn_pkg::VALUE_BITS+1)'(bl_b) - (fvn_pkg::VALUE_BITS+1)'(bl_a);
  assign xprod = fvn_pkg::PX_W'(xdiff) * fvn_pkg::PX_W'($signed({1'b0, wx_r}));
  assign xq    = (xprod + (xprod[fvn_pkg::PX_W-1] ? fvn_pkg::PX_W'(255)
                                                   : fvn_pkg::PX_W'(0))) >>> 8;
  assign xres  = (fvn_pkg::T_W'(bl_a) <<< 8) + fvn_pkg::T_W'(xq);

  // Blend along y.
  assign ydiff = (fvn_pkg::T_W+1)'(bot_r) - (fvn_pkg::T_W+1)'(top_r);
  assign yprod = fvn_pkg::YX_W'(ydiff) * fvn_pkg::YX_W'($signed({1'b0, wy_r}));
  assign yq    = (yprod + (yprod[fvn_pkg::YX_W-1] ? fvn_pkg::YX_W'(65535)
                                                   : fvn_pkg::YX_W'(0))) >>> 16;
  assign yres  = top_r + fvn_pkg::T_W'(yq);

  // Octave weighting.
  assign aprod = fvn_pkg::AX_W'(v_r) * fvn_pkg::AX_W'($signed({1'b0, p_r}));
  assign aq    = (aprod + (aprod[fvn_pkg::AX_W-1] ? fvn_pkg::AX_W'(65535)
                                                   : fvn_pkg::AX_W'(0))) >>> 16;

  // Amplitude update with rounding.
  assign pprod = (fvn_pkg::P_W+fvn_pkg::PERS_W+1)'(p_r)
               * (fvn_pkg::P_W+fvn_pkg::PERS_W+1)'(pers_r)
               + (fvn_pkg::P_W+fvn_pkg::PERS_W+1)'(32768);

  // Normalization numerator: sum * (1 - P).
  assign pers_cmp = fvn_pkg::P_W'(17'd65536 - fvn_pkg::P_W'(pers_r));
  assign fprod    = fvn_pkg::NUM_W'(sum_r) * fvn_pkg::NUM_W'($signed({1'b0, pers_cmp}));

  // Normalization divider step on the magnitude.
  assign frem_sh = {frem_r[fvn_pkg::FREM_W-2:0], fdvd_r[fvn_pkg::NUM_W-1]};
  assign f_ge    = frem_sh >= fvn_pkg::FREM_W'(den_r);

  // Saturation to the signed result range.
  assign pos_sat = fquo_r > fvn_pkg::NUM_W'(fvn_pkg::NOISE_MAX);
  assign neg_sat = fquo_r > fvn_pkg::NUM_W'(fvn_pkg::NOISE_MAX + 1);

  always_comb begin
    if (fneg_r) begin
      noise_res = neg_sat ? {1'b1, {(fvn_pkg::NOISE_W-1){1'b0}}}
                          : (~fquo_r[fvn_pkg::NOISE_W-1:0] + 1'b1);
    end else begin
      noise_res = pos_sat ? {1'b0, {(fvn_pkg::NOISE_W-1){1'b1}}}
                          : fquo_r[fvn_pkg::NOISE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. One octave runs setup, the corner fetch, two x blends, one
  // y blend, accumulate and step; then the sum is normalized and the result
  // waits in the output register.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    dvd_x_nxt     = dvd_x_r;
    dvd_y_nxt     = dvd_y_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    d_nxt         = d_r;
    div_cnt_nxt   = div_cnt_r;
    oct_nxt       = oct_r;
    n_nxt         = n_r;
    cy_nxt        = cy_r;
    base_nxt      = base_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_oor_nxt  = pend_oor_r;
    oor_nxt       = oor_r;
    corner_nxt    = corner_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    v_nxt         = v_r;
    sum_nxt       = sum_r;
    p_nxt         = p_r;
    fdvd_nxt      = fdvd_r;
    fquo_nxt      = fquo_r;
    frem_nxt      = frem_r;
    den_nxt       = den_r;
    fcnt_nxt      = fcnt_r;
    fneg_nxt      = fneg_r;
    out_valid_nxt = out_valid_r;
    out_noise_nxt = out_noise_r;
    out_oor_nxt   = out_oor_r;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.opcode == fvn_pkg::OP_QUERY)) begin
          if (oct_cfg_r == '0) begin
            n_nxt = fvn_pkg::OCT_W'(1);
          end else if (int'(oct_cfg_r) > fvn_pkg::MAX_OCTAVES) begin
            n_nxt = fvn_pkg::OCT_W'(fvn_pkg::MAX_OCTAVES);
          end else begin
            n_nxt = fvn_pkg::OCT_W'(oct_cfg_r);
          end
          dvd_x_nxt   = {in_ch.coord_x, {fvn_pkg::COS_TABLE_BITS{1'b0}}};
          dvd_y_nxt   = {in_ch.coord_y, {fvn_pkg::COS_TABLE_BITS{1'b0}}};
          d_nxt       = {cs_eff, 8'b0};
          rx_nxt      = '0;
          ry_nxt      = '0;
          qx_nxt      = '0;
          qy_nxt      = '0;
          div_cnt_nxt = '0;
          oct_nxt     = '0;
          sum_nxt     = '0;
          p_nxt       = fvn_pkg::P_W'(65536);
          oor_nxt     = 1'b0;
          state_nxt   = S_DIVXY;
        end
      end

      S_DIVXY: begin
        dvd_x_nxt   = dvd_x_r << 1;
        dvd_y_nxt   = dvd_y_r << 1;
        rx_nxt      = x_ge ? (rx_sh - fvn_pkg::REM_W'(d_r)) : rx_sh;
        ry_nxt      = y_ge ? (ry_sh - fvn_pkg::REM_W'(d_r)) : ry_sh;
        qx_nxt      = {qx_r[fvn_pkg::QUO_W-2:0], x_ge};
        qy_nxt      = {qy_r[fvn_pkg::QUO_W-2:0], y_ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == fvn_pkg::DIV_CNT_W'(fvn_pkg::DIVD_W - 1)) begin
          state_nxt = S_SETUP;
        end
      end

      S_SETUP: begin
        cy_nxt     = qy_r[fvn_pkg::QUO_W-1:fvn_pkg::COS_TABLE_BITS];
        base_nxt   = fvn_pkg::IDX_W'(cx_cell) * fvn_pkg::IDX_W'(stride_r);
        wx_nxt     = fvn_pkg::COS_LUT[qx_r[fvn_pkg::COS_TABLE_BITS-1:0]];
        wy_nxt     = fvn_pkg::COS_LUT[qy_r[fvn_pkg::COS_TABLE_BITS-1:0]];
        rd_cnt_nxt = '0;
        state_nxt  = S_READ;
      end

      S_READ: begin
        // Address goes out on counts zero to three; read data is captured on counts one to four.
        if (rd_cnt_r != 3'd4) begin
          pend_oor_nxt = !rd_in_range;
          if (!rd_in_range) begin
            oor_nxt = 1'b1;
          end
        end
        if (rd_cnt_r != 3'd0) begin
          corner_nxt[cap_sel] = pend_oor_r ? '0 : $signed(ram_rdata);
        end
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (rd_cnt_r == 3'd4) begin
          state_nxt = S_TOP;
        end
      end

      S_TOP: begin
        top_nxt   = xres;
        state_nxt = S_BOT;
      end

      S_BOT: begin
        bot_nxt   = xres;
        state_nxt = S_VMUL;
      end

      S_VMUL: begin
        v_nxt     = yres;
        state_nxt = S_ACC;
      end

      S_ACC: begin
        sum_nxt   = sum_r + fvn_pkg::SUM_W'(aq);
        state_nxt = S_NEXT;
      end

      S_NEXT: begin
        p_nxt   = fvn_pkg::P_W'(pprod >> 16);
        rx_nxt  = x_ge ? (rx_sh - fvn_pkg::REM_W'(d_r)) : rx_sh;
        ry_nxt  = y_ge ? (ry_sh - fvn_pkg::REM_W'(d_r)) : ry_sh;
        qx_nxt  = {qx_r[fvn_pkg::QUO_W-2:0], x_ge};
        qy_nxt  = {qy_r[fvn_pkg::QUO_W-2:0], y_ge};
        oct_nxt = oct_r + 1'b1;
        if (fvn_pkg::OCT_W'(oct_r + 1'b1) == n_r) begin
          state_nxt = S_MULF;
        end else begin
          state_nxt = S_SETUP;
        end
      end

      S_MULF: begin
        fdvd_nxt  = fprod;
        den_nxt   = fvn_pkg::DEN_W'(17'd65536 - p_r);
        state_nxt = S_ABS;
      end

      S_ABS: begin
        fneg_nxt  = fdvd_r[fvn_pkg::NUM_W-1];
        fdvd_nxt  = fdvd_r[fvn_pkg::NUM_W-1] ? (~fdvd_r + 1'b1) : fdvd_r;
        frem_nxt  = '0;
        fquo_nxt  = '0;
        fcnt_nxt  = '0;
        state_nxt = S_FDIV;
      end

      S_FDIV: begin
        fdvd_nxt = fdvd_r << 1;
        frem_nxt = f_ge ? (frem_sh - fvn_pkg::FREM_W'(den_r)) : frem_sh;
        fquo_nxt = {fquo_r[fvn_pkg::NUM_W-2:0], f_ge};
        fcnt_nxt = fcnt_r + 1'b1;
        if (fcnt_r == fvn_pkg::FCNT_W'(fvn_pkg::NUM_W - 1)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // Hold here only while an earlier result is still waiting.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_noise_nxt = noise_res;
          out_oor_nxt   = oor_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cfg_r <= fvn_pkg::OCT_CFG_W'(4);
      pers_r    <= fvn_pkg::PERS_W'(32768);
      csize_r   <= fvn_pkg::CELL_SIZE_W'(16);
      stride_r  <= fvn_pkg::STRIDE_W'(64);
    end else if (cfg_we) begin
      case (fvn_pkg::cfg_index_t'(cfg_index))
        fvn_pkg::CFG_OCTAVE_COUNT: oct_cfg_r <= cfg_wdata[fvn_pkg::OCT_CFG_W-1:0];
        fvn_pkg::CFG_PERSISTENCE:  pers_r    <= cfg_wdata[fvn_pkg::PERS_W-1:0];
        fvn_pkg::CFG_CELL_SIZE:    csize_r   <= cfg_wdata[fvn_pkg::CELL_SIZE_W-1:0];
        fvn_pkg::CFG_ROW_STRIDE:   stride_r  <= cfg_wdata[fvn_pkg::STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dvd_x_r     <= dvd_x_nxt;
    dvd_y_r     <= dvd_y_nxt;
    rx_r        <= rx_nxt;
    ry_r        <= ry_nxt;
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    d_r         <= d_nxt;
    div_cnt_r   <= div_cnt_nxt;
    oct_r       <= oct_nxt;
    n_r         <= n_nxt;
    cy_r        <= cy_nxt;
    base_r      <= base_nxt;
    wx_r        <= wx_nxt;
    wy_r        <= wy_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    pend_oor_r  <= pend_oor_nxt;
    oor_r       <= oor_nxt;
    corner_r    <= corner_nxt;
    top_r       <= top_nxt;
    bot_r       <= bot_nxt;
    v_r         <= v_nxt;
    sum_r       <= sum_nxt;
    p_r         <= p_nxt;
    fdvd_r      <= fdvd_nxt;
    fquo_r      <= fquo_nxt;
    frem_r      <= frem_nxt;
    den_r       <= den_nxt;
    fcnt_r      <= fcnt_nxt;
    fneg_r      <= fneg_nxt;
    out_noise_r <= out_noise_nxt;
    out_oor_r   <= out_oor_nxt;
  end

`ifndef NO_ASSERTIONS
  // A new result only appears as the sequencer leaves its final state.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final state");

  // Octave work never runs past the effective count.
  a_octave_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETUP || state_r == S_READ) |-> (oct_r < n_r))
    else $error("octave index beyond octave count");

  // The normalization divisor is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FDIV) |-> (den_r != '0))
    else $error("normalization divisor is zero");
`endif

endmodule

// ===== hdl/fvn_ram.sv =====
// ----------------------------------------------------------------------------
// fvn_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fractal value noise block. A queue of write and
// query items feeds a clocked driver; a bit-accurate predictor turns every
// accepted query into an expected noise value and range flag, which the
// output monitor compares against what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int  LAT_CYCLES  = 400;      // well above the duration of one query at the most octaves
  localparam longint MAX_CYCLES = 3000000;

  typedef struct {
    logic                                     opcode;
    logic [fvn_pkg::ENTRY_ADDR_W-1:0]         addr;
    logic signed [fvn_pkg::ENTRY_VALUE_W-1:0] value;
    logic [fvn_pkg::COORD_W-1:0]              x;
    logic [fvn_pkg::COORD_W-1:0]              y;
  } noise_item_t;

  typedef struct {
    logic signed [fvn_pkg::NOISE_W-1:0] noise;
    logic                               oor;
  } noise_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [fvn_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fvn_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  fvn_in_if  in_ch ();
  fvn_out_if out_ch ();

  fractal_value_noise_2d dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the block: configuration, lattice contents and the cosine
  // weights, all rebuilt here from the arithmetic the block is specified by.
  int unsigned   octaves_cfg = 4;
  int unsigned   persist_cfg = 32768;
  int unsigned   spacing_cfg = 16;
  int unsigned   stride_cfg  = 64;
  longint        lattice_mem [fvn_pkg::TABLE_DEPTH];
  bit            seeded      [fvn_pkg::TABLE_DEPTH];  // entries already queued for write
  longint        cos_weight  [fvn_pkg::COS_ENTRIES];

  noise_item_t   pending_items[$];
  noise_result_t expected_noise[$];
  int            errors = 0;
  int            queued = 0;    // items queued so far
  bit            calm = 1'b0;   // when set, neither side inserts gaps
  bit            hold_go = 1'b0;

  // Taylor series for sin in Q2.30, every step truncated toward zero.
  function automatic longint sine_q30(input longint u);
    longint u2, term, acc;
    u2   = (u * u) / (64'sd1 << 30);
    term = u;
    acc  = u;
    for (int n = 1; n <= 7; n++) begin
      term = -((term * u2) / (64'sd1 << 30)) / longint'((2 * n) * (2 * n + 1));
      acc += term;
    end
    return acc;
  endfunction

  // Splits one coordinate for octave o into its lattice cell and cosine weight.
  function automatic void split_axis(input longint coord, input int o,
                                     output longint cell_idx, output longint wt);
    longint div, scaled, frac;
    div      = longint'(spacing_cfg == 0 ? 1 : spacing_cfg) * 256;
    scaled   = coord << o;
    frac     = ((scaled % div) << 16) / div;
    cell_idx = scaled / div;
    wt       = cos_weight[(frac >> (16 - fvn_pkg::COS_TABLE_BITS))
                          & (fvn_pkg::COS_ENTRIES - 1)];
  endfunction

  function automatic int effective_octaves();
    if (octaves_cfg == 0) begin
      return 1;
    end
    return (octaves_cfg > fvn_pkg::MAX_OCTAVES) ? fvn_pkg::MAX_OCTAVES : octaves_cfg;
  endfunction

  function automatic longint corner_index(input longint cx, input longint cy);
    return cx * longint'(stride_cfg) + cy;
  endfunction

  function automatic longint fetch_corner(input longint idx, inout bit oor);
    if (idx >= fvn_pkg::TABLE_DEPTH) begin
      oor = 1'b1;
      return 0;
    end
    return lattice_mem[idx];
  endfunction

  function automatic noise_result_t predict_noise(input noise_item_t it);
    noise_result_t r;
    longint cx, cy, wx, wy, a, b, c, d, top, bot, v, acc, amp, res;
    bit     oor;
    acc = 0;
    amp = 65536;
    oor = 1'b0;
    for (int o = 0; o < effective_octaves(); o++) begin
      split_axis(longint'(it.x), o, cx, wx);
      split_axis(longint'(it.y), o, cy, wy);
      a   = fetch_corner(corner_index(cx, cy), oor);
      b   = fetch_corner(corner_index(cx + 1, cy), oor);
      c   = fetch_corner(corner_index(cx, cy + 1), oor);
      d   = fetch_corner(corner_index(cx + 1, cy + 1), oor);
      top = a * 256 + ((b - a) * wx) / 256;
      bot = c * 256 + ((d - c) * wx) / 256;
      v   = top + ((bot - top) * wy) / 65536;
      acc += (v * amp) / 65536;
      amp = (amp * longint'(persist_cfg) + 32768) >>> 16;
    end
    res = (acc * (65536 - longint'(persist_cfg))) / (65536 - amp);
    if (res > fvn_pkg::NOISE_MAX) begin
      res = fvn_pkg::NOISE_MAX;
    end
    if (res < -fvn_pkg::NOISE_MAX - 1) begin
      res = -fvn_pkg::NOISE_MAX - 1;
    end
    r.noise = res[fvn_pkg::NOISE_W-1:0];
    r.oor   = oor;
    return r;
  endfunction

  // Appends one item to the driver's queue.
  function automatic void enqueue_item(input noise_item_t it);
    pending_items.insert(pending_items.size(), it);
    queued++;
  endfunction

  function automatic void push_write(input int addr, input int value);
    noise_item_t it;
    it.opcode = fvn_pkg::OP_WRITE;
    it.addr   = addr[fvn_pkg::ENTRY_ADDR_W-1:0];
    it.value  = value[fvn_pkg::ENTRY_VALUE_W-1:0];
    it.x      = fvn_pkg::COORD_W'($urandom);
    it.y      = fvn_pkg::COORD_W'($urandom);
    seeded[addr] = 1'b1;
    enqueue_item(it);
  endfunction

  // Queues a query, preceded by writes for every in-range corner it will read
  // that has not been loaded yet, so no query ever reads an unwritten entry.
  function automatic void push_query(input longint x, input longint y);
    noise_item_t it;
    longint cx, cy, wx, wy, idx;
    for (int o = 0; o < effective_octaves(); o++) begin
      split_axis(x, o, cx, wx);
      split_axis(y, o, cy, wy);
      for (int k = 0; k < 4; k++) begin
        idx = corner_index(cx + (k & 1), cy + (k >> 1));
        if (idx < fvn_pkg::TABLE_DEPTH && !seeded[idx]) begin
          push_write(int'(idx), int'($urandom_range(0, 65535)));
        end
      end
    end
    it.opcode = fvn_pkg::OP_QUERY;
    it.addr   = fvn_pkg::ENTRY_ADDR_W'($urandom);
    it.value  = fvn_pkg::ENTRY_VALUE_W'($urandom);
    it.x      = x[fvn_pkg::COORD_W-1:0];
    it.y      = y[fvn_pkg::COORD_W-1:0];
    enqueue_item(it);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 45) begin
      return 0;
    end
    if (roll < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Coordinates mostly near the origin so the lattice is hit in range; the
  // full range is kept too, which drives corners off the table.
  function automatic longint pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 4095);
      3, 4, 5: return $urandom_range(0, 32767);
      6, 7:    return $urandom_range(0, 262143);
      default: return $urandom_range(0, (1 << fvn_pkg::COORD_W) - 1);
    endcase
  endfunction

  // Input driver: holds an offered item until taken, then waits out a gap.
  int in_gap = 0;
  always @(posedge clk) begin
    noise_item_t it;
    logic        nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_ch.opcode        <= it.opcode;
        in_ch.entry_address <= it.addr;
        in_ch.entry_value   <= it.value;
        in_ch.coord_x       <= it.x;
        in_ch.coord_y       <= it.y;
        nv     = 1'b1;
        in_gap = pick_gap();
      end
      in_ch.valid <= nv;
    end
  end

  // Every accepted input item updates the shadow table or yields a prediction.
  always @(posedge clk) begin
    noise_item_t it;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.opcode = in_ch.opcode;
      it.addr   = in_ch.entry_address;
      it.value  = in_ch.entry_value;
      it.x      = in_ch.coord_x;
      it.y      = in_ch.coord_y;
      if (it.opcode == fvn_pkg::OP_WRITE) begin
        lattice_mem[it.addr] = longint'(it.value);
      end else begin
        expected_noise.insert(expected_noise.size(), predict_noise(it));
      end
    end
  end

  // Long receiver hold-off, counted here, so the block fills and stalls input.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  int out_gap = 0;
  always @(posedge clk) begin
    logic nr;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      nr = 1'b0;
      if (hold_left == 0) begin
        if (out_gap > 0) begin
          out_gap = out_gap - 1;
        end else begin
          nr      = 1'b1;
          out_gap = pick_gap();
        end
      end
      out_ch.ready <= nr;
    end
  end

  // Result monitor: field by field against the oldest prediction.
  always @(posedge clk) begin
    noise_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_noise.size() == 0) begin
        $error("unexpected result item: noise_value %0d", out_ch.noise_value);
        errors++;
      end else begin
        want = expected_noise.pop_front();
        if (out_ch.noise_value !== want.noise) begin
          $error("noise_value expected %0d actual %0d", want.noise, out_ch.noise_value);
          errors++;
        end
        if (out_ch.index_out_of_range !== want.oor) begin
          $error("index_out_of_range expected %0b actual %0b",
                 want.oor, out_ch.index_out_of_range);
          errors++;
        end
      end
    end
  end

  longint cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Writes one register while the block is idle and mirrors it in the shadow.
  task automatic write_reg(input fvn_pkg::cfg_index_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[fvn_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fvn_pkg::CFG_OCTAVE_COUNT: octaves_cfg = value & 4'hF;
      fvn_pkg::CFG_PERSISTENCE:  persist_cfg = value & 16'hFFFF;
      fvn_pkg::CFG_CELL_SIZE:    spacing_cfg = value & 8'hFF;
      fvn_pkg::CFG_ROW_STRIDE:   stride_cfg  = value & 13'h1FFF;
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned oct, input int unsigned pers,
                            input int unsigned spacing, input int unsigned stride);
    write_reg(fvn_pkg::CFG_OCTAVE_COUNT, oct);
    write_reg(fvn_pkg::CFG_PERSISTENCE, pers);
    write_reg(fvn_pkg::CFG_CELL_SIZE, spacing);
    write_reg(fvn_pkg::CFG_ROW_STRIDE, stride);
  endtask

  // Waits until everything queued was taken and every result came back, then
  // lets a trailing write settle before the configuration may change.
  task automatic drain();
    while (pending_items.size() > 0 || expected_noise.size() > 0 || in_ch.valid) begin
      @(posedge clk);
    end
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  // Mix of random writes and well-formed queries under the current settings,
  // until about count items, the corner loads included, have been queued.
  task automatic random_phase(input int count);
    int start;
    start = queued;
    while (queued - start < count) begin
      if ($urandom_range(0, 3) == 0) begin
        push_write($urandom_range(0, fvn_pkg::TABLE_DEPTH - 1), $urandom_range(0, 65535));
      end else begin
        push_query(pick_coord(), pick_coord());
      end
    end
  endtask

  initial begin
    longint u, s, w;
    for (int k = 0; k < fvn_pkg::COS_ENTRIES; k++) begin
      u = ((longint'(k) * 64'sd3373259426) >>> fvn_pkg::COS_TABLE_BITS)
          - 64'sd3373259426 / 2;
      s = (64'sd1 << 30) + sine_q30(u);
      if (s < 0) begin
        s = 0;
      end
      w = (s + (64'sd1 << 14)) / (64'sd1 << 15);
      cos_weight[k] = (w > 65536) ? 65536 : w;
    end
    for (int k = 0; k < fvn_pkg::TABLE_DEPTH; k++) begin
      lattice_mem[k] = 0;
      seeded[k]      = 1'b0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: extreme lattice values at both ends of
    // the table, the origin, exact cell borders, and far coordinates whose
    // corners fall off the table.
    push_write(0, -32768);
    push_write(1, 32767);
    push_write(64, -1);
    push_write(65, 0);
    push_write(fvn_pkg::TABLE_DEPTH - 1, 32767);
    push_query(0, 0);
    push_query(4095, 4095);
    push_query(16 * 256, 16 * 256 + 128);
    push_query((1 << fvn_pkg::COORD_W) - 1, (1 << fvn_pkg::COORD_W) - 1);
    push_query(0, (1 << fvn_pkg::COORD_W) - 1);
    push_query(255, 1);
    drain();

    // Smallest settings: one octave, zero persistence, unit cells, unit stride.
    set_config(1, 0, 1, 1);
    push_query(0, 0);
    push_query(300, 700);
    random_phase(60);
    drain();

    // Largest octave count, persistence, cell size; long receiver hold-off, full flow.
    set_config(fvn_pkg::MAX_OCTAVES, 65535, 255, 4096);
    calm = 1'b1;
    random_phase(40);
    hold_go <= 1'b1;
    drain();
    calm = 1'b0;

    // Zero octave count and zero cell size are special cases; the stride is zero too.
    set_config(0, 12345, 0, 0);
    random_phase(60);
    drain();

    // Octave count above the maximum is clamped.
    set_config(15, 49152, 3, 100);
    random_phase(60);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_config($urandom_range(1, fvn_pkg::MAX_OCTAVES), $urandom_range(0, 65535),
                 $urandom_range(1, 64), $urandom_range(1, 256));
      calm = (ph == 1);
      random_phase(55);
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
